[design/prp_pkg.sv]
// ----------------------------------------------------------------------------
// prp_pkg: shared types and constants for the partial random permutation
// Pool size, field widths, sequencer states and register indexes.
// ----------------------------------------------------------------------------
package prp_pkg;

   // largest pool that the slot memory and touched map can hold
   localparam int MAX_POOL = 256;

   // derived widths
   localparam int IDX_W  = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
   localparam int CNT_W  = $clog2(MAX_POOL + 1);
   localparam int RAND_W = 32;
   localparam int STEP_W = $clog2(RAND_W);
   localparam int CFG_W  = 9;
   localparam int OUT_W  = 8;

   // register reset values
   localparam logic [CFG_W-1:0] POOL_SIZE_RESET  = 9'd256;
   localparam logic [CFG_W-1:0] PICK_COUNT_RESET = 9'd256;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [CNT_W:0]    cnt_wide_type;
   typedef logic [STEP_W-1:0] step_type;
   typedef logic [OUT_W-1:0]  out_word_type;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_POOL_SIZE  = 1'b0,
      CSR_PICK_COUNT = 1'b1
   } csr_index_type;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_RD_POS,
      S_RD_LAST,
      S_DONE
   } state_type;

endpackage

[design/partial_random_permutation.sv]
// ----------------------------------------------------------------------------
// partial_random_permutation: partial Fisher-Yates index shuffle
// Draws distinct indices from a pool, one per random word, using a serial
// remainder unit, a slot memory and a bitmap of touched slots.
// ----------------------------------------------------------------------------
// Each transaction on req_ brings one 32-bit random word and yields one
// index on rsp_ (none when the effective pick count is zero). An item is
// accepted in the idle state, then passes through the bit-serial restoring
// remainder unit (one dividend bit per cycle, reducing the word modulo the
// live count), then two slot memory reads through its single read port and a
// write back that also loads the output register. req_tready is high only
// while the sequencer is idle; a finished index may wait in the output
// register while the next word is taken. The pool size is the pool size
// register saturated to 256 and the run length is pick_count clamped to the
// pool size; the final index of a run carries rsp_tlast and clears the
// touched map at once, so no clearing pass exists. The user must write the
// registers through csr_ only while the block is idle; it does not enforce this.
module partial_random_permutation (
   input  logic        clock,
   input  logic        reset,
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [8:0]  csr_data,
   // random word stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] rand_word
   // picked index stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] picked_index
   output logic        rsp_tlast    // last
);

   // configuration registers
   logic [prp_pkg::CFG_W-1:0] pool_size_ff;
   logic [prp_pkg::CFG_W-1:0] pick_count_ff;

   // sequencer and run state
   prp_pkg::state_type              state_ff, state_in;
   prp_pkg::cnt_type                drawn_ff, drawn_in;
   logic [prp_pkg::MAX_POOL-1:0]    touched_ff, touched_in;

   // per-item working registers
   logic [prp_pkg::RAND_W-1:0] rand_ff, rand_in;
   prp_pkg::cnt_type           rem_ff, rem_in;
   prp_pkg::step_type          step_ff, step_in;
   prp_pkg::cnt_type           live_ff, live_in;
   prp_pkg::cnt_type           picks_ff, picks_in;
   prp_pkg::idx_type           val_ff, val_in;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   prp_pkg::out_word_type      rsp_index_ff, rsp_index_in;
   logic                       rsp_last_ff, rsp_last_in;

   // slot memory
   prp_pkg::idx_type           slot_mem [prp_pkg::MAX_POOL];
   prp_pkg::idx_type           mem_q_ff;
   logic                       mem_re;
   prp_pkg::idx_type           mem_ra;
   logic                       mem_we;
   prp_pkg::idx_type           mem_wa;
   prp_pkg::idx_type           mem_wd;

   // combinational helpers
   prp_pkg::cnt_type           pool_n;
   prp_pkg::cnt_type           picks_eff;
   prp_pkg::cnt_type           drawn_eff;
   prp_pkg::cnt_wide_type     div_shift;
   prp_pkg::cnt_wide_type     div_live;
   prp_pkg::idx_type           pos;
   prp_pkg::idx_type           last_slot;
   prp_pkg::cnt_type           live_m1;
   prp_pkg::cnt_type           drawn_inc;
   logic                       run_end;
   logic                       out_load;
   logic                       req_take;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == prp_pkg::S_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_index_ff;
   assign rsp_tlast  = rsp_last_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_size_ff  <= prp_pkg::POOL_SIZE_RESET;
         pick_count_ff <= prp_pkg::PICK_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (prp_pkg::csr_index_type'(csr_index))
            prp_pkg::CSR_POOL_SIZE:  pool_size_ff  <= csr_data;
            prp_pkg::CSR_PICK_COUNT: pick_count_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // effective pool size and run length
   always_comb begin
      if (int'(pool_size_ff) > prp_pkg::MAX_POOL) begin
         pool_n = prp_pkg::cnt_type'(prp_pkg::MAX_POOL);
      end else begin
         pool_n = prp_pkg::cnt_type'(pool_size_ff);
      end
      if (int'(pick_count_ff) > int'(pool_n)) begin
         picks_eff = pool_n;
      end else begin
         picks_eff = prp_pkg::cnt_type'(pick_count_ff);
      end
   end

   // datapath views
   assign pos       = rem_ff[prp_pkg::IDX_W-1:0];
   assign live_m1   = live_ff - 1'b1;
   assign last_slot = live_m1[prp_pkg::IDX_W-1:0];
   assign drawn_inc = drawn_ff + 1'b1;
   assign run_end   = (drawn_inc == picks_ff);
   assign div_shift = {rem_ff, rand_ff[prp_pkg::RAND_W-1]};
   assign div_live  = {1'b0, live_ff};
   assign out_load  = (state_ff == prp_pkg::S_DONE) && (!rsp_valid_ff || rsp_tready);

   // sequencer state register and control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= prp_pkg::S_IDLE;
         drawn_ff     <= '0;
         touched_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         drawn_ff     <= drawn_in;
         touched_ff   <= touched_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and output payload registers
   always_ff @(posedge clock) begin
      rand_ff      <= rand_in;
      rem_ff       <= rem_in;
      step_ff      <= step_in;
      live_ff      <= live_in;
      picks_ff     <= picks_in;
      val_ff       <= val_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // next state, remainder step and memory control
   always_comb begin
      state_in     = state_ff;
      drawn_in     = drawn_ff;
      touched_in   = touched_ff;
      rand_in      = rand_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      live_in      = live_ff;
      picks_in     = picks_ff;
      val_in       = val_ff;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      drawn_eff    = drawn_ff;
      mem_re       = 1'b0;
      mem_ra       = pos;
      mem_we       = 1'b0;
      mem_wa       = pos;
      mem_wd       = val_ff;

      case (state_ff)
         prp_pkg::S_IDLE: begin
            // accept a word; a zero run length consumes it with no result
            if (req_take && (picks_eff != '0)) begin
               if (drawn_ff >= picks_eff) begin
                  drawn_eff  = '0;
                  drawn_in   = '0;
                  touched_in = '0;
               end
               live_in  = pool_n - drawn_eff;
               picks_in = picks_eff;
               rand_in  = req_tdata;
               rem_in   = '0;
               step_in  = prp_pkg::step_type'(prp_pkg::RAND_W - 1);
               state_in = prp_pkg::S_DIV;
            end
         end
         prp_pkg::S_DIV: begin
            // one restoring remainder step per cycle, msb first
            if (div_shift >= div_live) begin
               rem_in = prp_pkg::cnt_type'(div_shift - div_live);
            end else begin
               rem_in = div_shift[prp_pkg::CNT_W-1:0];
            end
            rand_in = {rand_ff[prp_pkg::RAND_W-2:0], 1'b0};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = prp_pkg::S_RD_POS;
            end
         end
         prp_pkg::S_RD_POS: begin
            // fetch the picked slot
            mem_re   = 1'b1;
            mem_ra   = pos;
            state_in = prp_pkg::S_RD_LAST;
         end
         prp_pkg::S_RD_LAST: begin
            // resolve the picked value, fetch the last live slot
            val_in   = touched_ff[pos] ? mem_q_ff : pos;
            mem_re   = 1'b1;
            mem_ra   = last_slot;
            state_in = prp_pkg::S_DONE;
         end
         prp_pkg::S_DONE: begin
            // move the last live value into the picked slot and emit
            if (out_load) begin
               mem_we       = 1'b1;
               mem_wa       = pos;
               mem_wd       = touched_ff[last_slot] ? mem_q_ff : last_slot;
               rsp_valid_in = 1'b1;
               rsp_index_in = prp_pkg::out_word_type'(val_ff);
               rsp_last_in  = run_end;
               if (run_end) begin
                  drawn_in   = '0;
                  touched_in = '0;
               end else begin
                  drawn_in        = drawn_inc;
                  touched_in[pos] = 1'b1;
               end
               state_in = prp_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = prp_pkg::S_IDLE;
         end
      endcase
   end

   // slot memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         mem_q_ff <= slot_mem[mem_ra];
      end
   end

`ifndef SYNTHESIS
   // the remainder stays below the live count throughout the reduction
   a_rem_below_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == prp_pkg::S_DIV || state_ff == prp_pkg::S_RD_POS) |-> (rem_ff < live_ff))
      else $error("remainder reached the live count");

   // a busy item always has at least one live slot
   a_live_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff != prp_pkg::S_IDLE) |-> (live_ff != '0))
      else $error("item in progress with an empty pool");

   // picks made so far stay below the run length while an item is at work
   a_drawn_below_picks: assert property (@(posedge clock) disable iff (reset)
      (state_ff != prp_pkg::S_IDLE) |-> (drawn_ff < picks_ff))
      else $error("run overran its pick count");

   // the final pick of a run leaves the touched map and drawn count clear and raises rsp_tlast
   a_run_end_clears: assert property (@(posedge clock) disable iff (reset)
      (out_load && run_end) |=> (touched_ff == '0 && drawn_ff == '0 && rsp_tlast))
      else $error("run end did not clear the run state");
`endif

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for partial_random_permutation
// Feeds random words through the req_ stream, models the partial shuffle in
// a scoreboard and compares every index and end-of-run flag on rsp_.
// ----------------------------------------------------------------------------
module testbench;

   localparam int RANDOM_WORDS  = 1600;
   localparam int DRAIN_CYCLES  = 45;
   localparam int HOLD_CYCLES   = 400;
   localparam int STALL_LIMIT   = 3000;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [prp_pkg::OUT_W-1:0] index;
      logic                      last;
   } pick_type;

   // shuffle predictor plus queue of expected indices
   class pick_scoreboard;
      logic [prp_pkg::CFG_W-1:0] pool_len;
      logic [prp_pkg::CFG_W-1:0] run_len;
      logic [prp_pkg::OUT_W-1:0] slot_mem [prp_pkg::MAX_POOL];
      bit                        touched [prp_pkg::MAX_POOL];
      int unsigned               drawn;
      pick_type                  expected_picks [$];
      int unsigned               failures;
      int unsigned               indices_checked;
      int unsigned               runs_done;

      function new();
         pool_len = prp_pkg::POOL_SIZE_RESET;
         run_len  = prp_pkg::PICK_COUNT_RESET;
         failures = 0;
         indices_checked = 0;
         runs_done = 0;
         foreach (slot_mem[i]) slot_mem[i] = '0;
         restart_run();
      endfunction

      function void restart_run();
         foreach (touched[i]) touched[i] = 1'b0;
         drawn = 0;
      endfunction

      function void set_reg(prp_pkg::csr_index_type idx, logic [prp_pkg::CFG_W-1:0] value);
         if (idx == prp_pkg::CSR_POOL_SIZE) pool_len = value;
         else run_len = value;
      endfunction

      // untouched slots hold their own index
      function logic [prp_pkg::OUT_W-1:0] slot_value(int unsigned slot);
         return touched[slot] ? slot_mem[slot] : slot[prp_pkg::OUT_W-1:0];
      endfunction

      function int unsigned pending();
         return expected_picks.size();
      endfunction

      // one accepted word: draw the next index of the run, if any
      function void note_word(logic [31:0] word);
         int unsigned pool, picks, live, pos;
         pick_type    pick;
         pool  = (pool_len > prp_pkg::MAX_POOL) ? prp_pkg::MAX_POOL : pool_len;
         picks = (run_len > pool) ? pool : run_len;
         if (picks == 0) return;
         if (drawn >= picks) restart_run();
         live = pool - drawn;
         pos  = word % live;
         pick.index = slot_value(pos);
         slot_mem[pos] = slot_value(live - 1);
         touched[pos] = 1'b1;
         drawn++;
         pick.last = (drawn >= picks);
         if (pick.last) restart_run();
         expected_picks = {expected_picks, pick};
      endfunction

      function void flag_failure(string msg);
         failures++;
         if (failures <= REPORT_LIMIT) $display("mismatch: %s", msg);
      endfunction

      function void check_pick(logic [prp_pkg::OUT_W-1:0] index, logic last);
         pick_type want;
         if (expected_picks.size() == 0) begin
            flag_failure($sformatf("unexpected index %0d last %0b", index, last));
            return;
         end
         want = expected_picks.pop_front();
         indices_checked++;
         if (want.last) runs_done++;
         if (want.index !== index || want.last !== last)
            flag_failure($sformatf("index expected %0d got %0d, last expected %0b got %0b",
                                   want.index, index, want.last, last));
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   prp_pkg::csr_index_type     csr_index = prp_pkg::CSR_POOL_SIZE;
   logic [prp_pkg::CFG_W-1:0]  csr_data = '0;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [31:0]                req_tdata = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [7:0]                 rsp_tdata;
   logic                       rsp_tlast;

   pick_scoreboard board = new();
   bit             steady = 1'b0;
   bit             hold_pending = 1'b0;
   int unsigned    words_sent = 0;
   int unsigned    settings_done = 0;
   int unsigned    quiet_cycles = 0;

   partial_random_permutation dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: random back-pressure, one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_tready <= steady || ($urandom_range(99) >= 15);
         end
      end
   end

   // check each result transaction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_pick(rsp_tdata, rsp_tlast);
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout after %0d quiet cycles", quiet_cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   // offer one word, with an occasional gap ahead of it
   task automatic send_word(input logic [31:0] word);
      if (!steady && $urandom_range(99) < 15) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 40)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      board.note_word(word);
      words_sent++;
      @(negedge clock);
   endtask

   // write both registers once the block has gone quiet
   task automatic write_regs(input int unsigned len, input int unsigned picks);
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= prp_pkg::CSR_POOL_SIZE;
      csr_data  <= len[prp_pkg::CFG_W-1:0];
      do @(posedge clock); while (!csr_ready);
      board.set_reg(prp_pkg::CSR_POOL_SIZE, len[prp_pkg::CFG_W-1:0]);
      @(negedge clock);
      csr_index <= prp_pkg::CSR_PICK_COUNT;
      csr_data  <= picks[prp_pkg::CFG_W-1:0];
      do @(posedge clock); while (!csr_ready);
      board.set_reg(prp_pkg::CSR_PICK_COUNT, picks[prp_pkg::CFG_W-1:0]);
      @(negedge clock);
      csr_valid <= 1'b0;
      settings_done++;
   endtask

   // mostly full-range words, with the edges and small values mixed in
   function automatic logic [31:0] random_word();
      case ($urandom_range(9))
         0:       return 32'h0;
         1:       return 32'hFFFF_FFFF;
         2, 3:    return $urandom_range(0, 1023);
         default: return $urandom;
      endcase
   endfunction

   // main sequence
   initial begin
      int unsigned len, picks, pool, runs_len, count, random_sent;

      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: word extremes, leaves a run open
      send_word(32'h0);
      send_word(32'hFFFF_FFFF);
      send_word(32'h8000_0000);
      send_word(32'd255);
      send_word(32'd256);

      // single-slot pool, open run closed by the new pick count
      write_regs(1, 1);
      send_word($urandom);
      send_word(32'hFFFF_FFFF);

      // zero pool length and zero pick count give nothing
      write_regs(0, 5);
      send_word($urandom);
      write_regs(5, 0);
      send_word($urandom);

      // pool length above the maximum saturates
      write_regs(511, 2);
      send_word(32'hFFFF_FFFF);
      send_word(32'h0);

      // short complete run
      write_regs(3, 3);
      repeat (3) send_word(32'h0);

      // settings changed mid-run: restart, then carry on, then shrink the pool
      write_regs(10, 10);
      repeat (4) send_word(random_word());
      write_regs(10, 3);
      send_word(random_word());
      write_regs(10, 8);
      repeat (2) send_word(random_word());
      write_regs(6, 8);
      repeat (3) send_word(random_word());

      // full pool while the receiver holds off, so the input backs up
      write_regs(256, 256);
      hold_pending = 1'b1;
      random_sent = 0;
      repeat (8) begin
         send_word(random_word());
         random_sent++;
      end

      // random settings, mostly whole runs with random content
      while (random_sent < RANDOM_WORDS) begin
         case ($urandom_range(19))
            0:       len = 0;
            1:       len = $urandom_range(257, 511);
            2, 3:    len = 256;
            4:       len = 1;
            default: len = $urandom_range(2, 24);
         endcase
         case ($urandom_range(9))
            0:       picks = 0;
            1:       picks = $urandom_range(len, 511);
            2:       picks = len;
            default: picks = $urandom_range(1, (len == 0) ? 1 : len);
         endcase
         pool     = (len > prp_pkg::MAX_POOL) ? prp_pkg::MAX_POOL : len;
         runs_len = (picks > pool) ? pool : picks;
         if (runs_len == 0)
            count = $urandom_range(1, 3);
         else
            count = runs_len * $urandom_range(1, 2) + $urandom_range(0, 3);
         if (count > 300) count = 300;
         write_regs(len, picks);
         repeat (count) begin
            if (random_sent == 400) steady = 1'b1;
            if (random_sent == 700) steady = 1'b0;
            send_word(random_word());
            if (runs_len != 0) random_sent++;
         end
      end
      req_tvalid <= 1'b0;
      steady = 1'b0;

      // drain and watch for stray results
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d words across %0d register settings", words_sent, settings_done);
      $display("checked %0d indices, %0d runs ended with last", board.indices_checked,
               board.runs_done);
      if (board.failures == 0) begin
         $display("No mismatches found");
      end else begin
         $display("%0d failures in total", board.failures);
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
